@@ sv/untp_pkg.sv @@
package untp_pkg;

  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_BASE = 2'd1;
  localparam logic [1:0] ST_BAD_NUM  = 2'd2;
  localparam logic [1:0] ST_TOO_BIG  = 2'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [5:0] NO_DIGIT  = 6'd36;
  localparam logic [5:0] BASE_MIN  = 6'd2;
  localparam logic [5:0] BASE_MAX  = 6'd36;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;
  localparam logic [5:0] PFX_SAT   = 6'd63;

  localparam logic [31:0] BYTE_MAX = 32'd255;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [COUNT_BITS+1:0] wcnt_t;

  // classified input word as it sits in the queue
  typedef struct packed {
    logic        action;
    logic [7:0]  ch;
    logic [5:0]  digit;
    logic        is_space;
    logic        is_amp;
    logic        is_under;
    logic [5:0]  base;
    logic [2:0]  flags;
    logic [31:0] limit;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [15:0] consumed;
  } res_t;

  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [5:0] d;
    d = NO_DIGIT;
    if (c >= 8'h30 && c <= 8'h39) d = 6'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h7A) d = 6'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h5A) d = 6'(c - 8'h37);
    return d;
  endfunction

  function automatic cnt_t cnt_inc(input cnt_t x);
    return (x == CNT_MAX) ? x : cnt_t'(x + cnt_t'(1));
  endfunction

  function automatic logic [15:0] to_consumed(input cnt_t c);
    logic [32:0] w;
    w = 33'(c);
    return (w > 33'h0FFFF) ? 16'hFFFF : w[15:0];
  endfunction

endpackage

@@ sv/untp_in_if.sv @@
interface untp_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  char_in;
  logic [31:0] base_spec;
  logic [31:0] limit_in;

  modport source(output valid, action, char_in, base_spec, limit_in, input ready);
  modport sink(input valid, action, char_in, base_spec, limit_in, output ready);
endinterface

@@ sv/untp_out_if.sv @@
interface untp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] value;
  logic [15:0] consumed;

  modport source(output valid, status, value, consumed, input ready);
  modport sink(input valid, status, value, consumed, output ready);
endinterface

@@ sv/unsigned_number_text_parser_top.sv @@
// channel   dir   payload
// text      in    action, char_in[7:0], base_spec[31:0], limit_in[31:0]
// result    out   status[1:0], value[31:0], consumed[15:0]
//
// one word per cycle sustained while no result is stalled; a result is
// registered in the cycle after its word is taken from the two-entry queue
// rst is synchronous and empties the queue, drops any pending result and
// returns the parser to idle with base 10
// a stalled result holds the back end; the queue keeps taking words until full
module unsigned_number_text_parser_top (
  input  logic       clk,
  input  logic       rst,
  untp_in_if.sink    text,
  untp_out_if.source result
);
  import untp_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  untp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .text    (text),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  untp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .result  (result)
  );

`ifndef SYNTH
  // a full queue always has a word to offer
  a_full_has_word: assert property (@(posedge clk) disable iff (rst)
    !text.ready |-> q_valid)
    else $error("queue full without a word at its head");

  // a fresh result must come from a word taken from the queue
  a_result_from_word: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(q_valid && q_ready))
    else $error("result without a queued word");

  a_bad_base_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status == ST_BAD_BASE |-> result.value == 32'd0)
    else $error("bad base result with nonzero value");
`endif

endmodule

@@ sv/untp_front.sv @@
module untp_front (
  input  logic          clk,
  input  logic          rst,
  untp_in_if.sink       text,
  output logic          q_valid,
  input  logic          q_ready,
  output untp_pkg::item_t q_item
);
  import untp_pkg::*;

  item_t              slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  item_t              cls;
  logic               push;
  logic               pop;

  // decode the word before it enters the queue
  always_comb begin
    cls          = '0;
    cls.action   = text.action;
    cls.ch       = text.char_in;
    cls.digit    = digit_of(text.char_in);
    cls.is_space = (text.char_in == CH_SPACE);
    cls.is_amp   = (text.char_in == CH_AMP);
    cls.is_under = (text.char_in == CH_UNDER);
    if (text.base_spec[7:0] < 8'(BASE_MIN) || text.base_spec[7:0] > 8'(BASE_MAX)) begin
      cls.base = BASE_DEC;
    end else begin
      cls.base = text.base_spec[5:0];
    end
    cls.flags = text.base_spec[31:29];
    cls.limit = text.limit_in;
  end

  assign text.ready = (count != QCNT_W'(QDEPTH));
  assign push       = text.valid && text.ready;
  assign q_valid    = (count != '0);
  assign pop        = q_valid && q_ready;
  assign q_item     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

@@ sv/untp_back.sv @@
module untp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  untp_pkg::item_t q_item,
  untp_out_if.source      result
);
  import untp_pkg::*;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SPACES = 2'd1;
  localparam logic [1:0] PH_LOOK   = 2'd2;
  localparam logic [1:0] PH_DIGITS = 2'd3;

  logic [1:0]  phase, phase_next;
  logic [5:0]  active_base, active_base_next;
  logic [2:0]  check_flags, check_flags_next;
  logic [31:0] held_limit, held_limit_next;
  logic [31:0] accumulator, accumulator_next;
  logic        digit_seen, digit_seen_next;
  logic [5:0]  dec_val, dec_val_next;
  logic        dec_seen, dec_seen_next;
  logic        dec_dead, dec_dead_next;
  logic        def_stopped, def_stopped_next;
  logic [7:0]  def_stop_char, def_stop_char_next;
  cnt_t        space_count, space_count_next;
  cnt_t        char_count, char_count_next;
  cnt_t        default_len, default_len_next;

  logic        out_valid;
  res_t        out_res;
  logic        take;
  logic        produce;
  res_t        res;
  logic [31:0] mac;
  logic        in_base;
  logic [9:0]  dec_sum;
  wcnt_t       pfx_sum;
  wcnt_t       run_sum;

  function automatic res_t finish(input logic seen, input logic [31:0] acc,
                                  input cnt_t cons, input logic [7:0] stopc,
                                  input logic [2:0] flags, input logic [31:0] lim);
    res_t r;
    r.value    = acc;
    r.consumed = to_consumed(cons);
    if (!seen) begin
      r.status = ST_BAD_NUM;
      r.value  = '0;
    end else if ((flags[0] && acc > lim) || (flags[1] && acc > BYTE_MAX)) begin
      r.status = ST_TOO_BIG;
    end else if (flags[2] && stopc > CH_SPACE) begin
      r.status = ST_BAD_NUM;
    end else begin
      r.status = ST_OK;
    end
    return r;
  endfunction

  assign q_ready = !out_valid || result.ready;
  assign take    = q_valid && q_ready;

  assign mac     = accumulator * 32'(active_base) + 32'(q_item.digit);
  assign in_base = (q_item.digit < active_base);
  assign dec_sum = 10'(dec_val) * 10'd10 + 10'(q_item.digit);
  assign pfx_sum = wcnt_t'(space_count) + wcnt_t'(char_count) + wcnt_t'(1);
  assign run_sum = wcnt_t'(space_count) + wcnt_t'(default_len);

  always_comb begin
    phase_next         = phase;
    active_base_next   = active_base;
    check_flags_next   = check_flags;
    held_limit_next    = held_limit;
    accumulator_next   = accumulator;
    digit_seen_next    = digit_seen;
    dec_val_next       = dec_val;
    dec_seen_next      = dec_seen;
    dec_dead_next      = dec_dead;
    def_stopped_next   = def_stopped;
    def_stop_char_next = def_stop_char;
    space_count_next   = space_count;
    char_count_next    = char_count;
    default_len_next   = default_len;
    produce            = 1'b0;
    res                = '0;

    if (take) begin
      if (!q_item.action) begin
        phase_next         = PH_SPACES;
        active_base_next   = q_item.base;
        check_flags_next   = q_item.flags;
        held_limit_next    = q_item.limit;
        accumulator_next   = '0;
        digit_seen_next    = 1'b0;
        dec_val_next       = '0;
        dec_seen_next      = 1'b0;
        dec_dead_next      = 1'b0;
        def_stopped_next   = 1'b0;
        def_stop_char_next = '0;
        space_count_next   = '0;
        char_count_next    = '0;
        default_len_next   = '0;
      end else begin
        case (phase)
          PH_IDLE: begin
          end
          PH_SPACES, PH_LOOK: begin
            if (phase == PH_SPACES && q_item.is_space) begin
              space_count_next = cnt_inc(space_count);
            end else if (phase == PH_SPACES && q_item.is_amp) begin
              active_base_next = BASE_HEX;
              char_count_next  = cnt_inc(space_count);
              phase_next       = PH_DIGITS;
            end else begin
              phase_next = PH_LOOK;
              // default-base run
              if (!def_stopped) begin
                if (in_base) begin
                  accumulator_next = mac;
                  digit_seen_next  = 1'b1;
                  default_len_next = cnt_inc(default_len);
                end else begin
                  def_stopped_next   = 1'b1;
                  def_stop_char_next = q_item.ch;
                end
              end
              // decimal prefix run
              if (!dec_dead) begin
                if (q_item.digit < BASE_DEC) begin
                  dec_val_next    = (dec_sum > 10'(PFX_SAT)) ? PFX_SAT : dec_sum[5:0];
                  dec_seen_next   = 1'b1;
                  char_count_next = cnt_inc(char_count);
                end else if (q_item.is_under && dec_seen) begin
                  if (dec_val < BASE_MIN || dec_val > BASE_MAX) begin
                    produce      = 1'b1;
                    res.status   = ST_BAD_BASE;
                    res.value    = '0;
                    res.consumed = to_consumed(space_count);
                    phase_next   = PH_IDLE;
                  end else begin
                    active_base_next = dec_val;
                    accumulator_next = '0;
                    digit_seen_next  = 1'b0;
                    char_count_next  = (pfx_sum > wcnt_t'(CNT_MAX)) ? CNT_MAX
                                                                    : pfx_sum[COUNT_BITS-1:0];
                    phase_next       = PH_DIGITS;
                  end
                end else begin
                  dec_dead_next = 1'b1;
                end
              end
              // both runs over: accumulator did not move this word
              if (dec_dead_next && def_stopped_next) begin
                produce    = 1'b1;
                res        = finish(digit_seen, accumulator,
                                    run_sum[COUNT_BITS] ? CNT_MAX : run_sum[COUNT_BITS-1:0],
                                    def_stopped ? def_stop_char : q_item.ch,
                                    check_flags, held_limit);
                phase_next = PH_IDLE;
              end
            end
          end
          PH_DIGITS: begin
            if (in_base) begin
              accumulator_next = mac;
              digit_seen_next  = 1'b1;
              char_count_next  = cnt_inc(char_count);
            end else begin
              produce    = 1'b1;
              res        = finish(digit_seen, accumulator, char_count, q_item.ch,
                                  check_flags, held_limit);
              phase_next = PH_IDLE;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      active_base   <= BASE_DEC;
      check_flags   <= '0;
      held_limit    <= '0;
      accumulator   <= '0;
      digit_seen    <= 1'b0;
      dec_val       <= '0;
      dec_seen      <= 1'b0;
      dec_dead      <= 1'b0;
      def_stopped   <= 1'b0;
      def_stop_char <= '0;
      space_count   <= '0;
      char_count    <= '0;
      default_len   <= '0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      active_base   <= active_base_next;
      check_flags   <= check_flags_next;
      held_limit    <= held_limit_next;
      accumulator   <= accumulator_next;
      digit_seen    <= digit_seen_next;
      dec_val       <= dec_val_next;
      dec_seen      <= dec_seen_next;
      dec_dead      <= dec_dead_next;
      def_stopped   <= def_stopped_next;
      def_stop_char <= def_stop_char_next;
      space_count   <= space_count_next;
      char_count    <= char_count_next;
      default_len   <= default_len_next;
      if (take && produce) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && produce) begin
      out_res <= res;
    end
  end

  assign result.valid    = out_valid;
  assign result.status   = out_res.status;
  assign result.value    = out_res.value;
  assign result.consumed = out_res.consumed;

endmodule
